### rtl/cqrk_pkg.sv
package cqrk_pkg;

   // Field widths of the stream items.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned TDATA_W  = 40;

   // Operation codes carried on the request tuser.
   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_REVERSE = 2'd2
   } op_type;

   // Status codes carried on the response tuser.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_BADK  = 2'd3
   } status_type;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      IDLE      = 6'b000001,
      DEQ_READ  = 6'b000010,
      SWAP_RD_A = 6'b000100,
      SWAP_RD_B = 6'b001000,
      SWAP_WR_A = 6'b010000,
      SWAP_WR_B = 6'b100000
   } state_type;

   // One response item as held in the output register.
   typedef struct packed {
      logic [WORD_W-1:0]  data;
      status_type         status;
      logic [COUNT_W-1:0] occupancy;
   } rsp_type;

endpackage

### rtl/cqrk_mem.sv
// Simple dual-port RAM: one write port, one read port, read data registered.
module cqrk_mem
   import cqrk_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/circular_queue_reverse_first_k.sv
// Bounded circular FIFO of signed 32-bit words that can also reverse the order of its
// oldest k elements in place. Each request item carries an operation on req_tuser
// (enqueue, dequeue, reverse first k) and yields exactly one response item with the
// dequeued word, a status (ok, full, empty, bad count) on rsp_tuser and the occupancy
// after the operation. On any error nothing changes and the returned word is zero.
// The words live in a single RAM with one write and one registered read port, so the
// cost of an item is set by that RAM: enqueue, errors and trivial reversals finish in
// the accept cycle, a dequeue waits for the registered RAM read, and a reversal of k
// elements runs floor(k/2) swaps, each of two reads and two writes through the single
// pair of ports. One item is in work at a time; a finished response sits in an output
// register, and the next request is taken as soon as the sequencer is idle and that
// register is empty or being drained. The RAM needs no clearing after reset because
// only slots holding queued words are read.
module circular_queue_reverse_first_k
   import cqrk_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [31:0] value, [36:32] reverse_count, rest 0
   input  logic [OP_W-1:0]    req_tuser,   // [1:0] op
   // Response channel.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [31:0] data_out, [36:32] occupancy, rest 0
   output logic [STATUS_W-1:0] rsp_tuser   // [1:0] status
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   // Width for comparing the request count with the occupancy.
   localparam int KW  = (CW > COUNT_W) ? CW : COUNT_W;
   // Width for head plus count, which stays below twice the depth.
   localparam int SW  = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

   // Control state.
   state_type               state_ff, state_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   // Swap sequencer and payload.
   logic [AW-1:0]           a_ff, a_in;
   logic [AW-1:0]           b_ff, b_in;
   logic [COUNT_W-2:0]      left_ff, left_in;
   logic [WORD_W-1:0]       hold_ff, hold_in;
   rsp_type                 rsp_ff, rsp_in;

   // RAM ports.
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [WORD_W-1:0]       wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [WORD_W-1:0]       rd_data;

   logic                    accept;
   logic [WORD_W-1:0]       req_value;
   logic [COUNT_W-1:0]      req_count;
   logic [AW-1:0]           tail_next;
   logic [AW-1:0]           head_next;
   logic [SW-1:0]           last_sum;
   logic [AW-1:0]           last_slot;
   logic [CW-1:0]           count_inc;
   logic [CW-1:0]           count_dec;

   cqrk_mem #(
      .DEPTH (DEPTH),
      .WIDTH (WORD_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_value = req_tdata[WORD_W-1:0];
   assign req_count = req_tdata[WORD_W+COUNT_W-1:WORD_W];

   // A new request is taken only when the sequencer is free and the response
   // register will be empty at the next edge.
   assign req_tready = (state_ff == IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign tail_next = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + AW'(1);
   assign head_next = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);

   // Slot of the k-th element counted from the head; only used when k is at least
   // two and within the occupancy, so the sum is below twice the depth.
   assign last_sum  = SW'(head_ff) + SW'(req_count) - SW'(1);
   assign last_slot = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      left_in      = left_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = a_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = a_ff;

      case (state_ff)
         IDLE: begin
            if (accept) begin
               rsp_in.data      = '0;
               rsp_in.status    = STATUS_OK;
               rsp_in.occupancy = COUNT_W'(count_ff);
               case (op_type'(req_tuser))
                  OP_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        wr_addr          = tail_next;
                        wr_data          = req_value;
                        tail_in          = tail_next;
                        count_in         = count_inc;
                        rsp_in.occupancy = COUNT_W'(count_inc);
                     end
                  end
                  OP_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        // The word arrives from the RAM in the next cycle.
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = head_next;
                        count_in = count_dec;
                        state_in = DEQ_READ;
                     end
                  end
                  OP_REVERSE: begin
                     if (KW'(req_count) > KW'(count_ff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_BADK;
                     end else if (req_count < COUNT_W'(2)) begin
                        // Reversing zero or one element leaves the queue as it is.
                        rsp_valid_in = 1'b1;
                     end else begin
                        a_in     = head_ff;
                        b_in     = last_slot;
                        left_in  = req_count[COUNT_W-1:1];
                        state_in = SWAP_RD_A;
                     end
                  end
                  default: begin
                     // The unused operation code is answered ok and changes nothing.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         DEQ_READ: begin
            rsp_valid_in     = 1'b1;
            rsp_in.data      = rd_data;
            rsp_in.status    = STATUS_OK;
            rsp_in.occupancy = COUNT_W'(count_ff);
            state_in         = IDLE;
         end
         SWAP_RD_A: begin
            rd_en    = 1'b1;
            rd_addr  = a_ff;
            state_in = SWAP_RD_B;
         end
         SWAP_RD_B: begin
            // The front word is on the read port now; park it while the back
            // word is fetched.
            rd_en    = 1'b1;
            rd_addr  = b_ff;
            hold_in  = rd_data;
            state_in = SWAP_WR_A;
         end
         SWAP_WR_A: begin
            wr_en    = 1'b1;
            wr_addr  = a_ff;
            wr_data  = rd_data;
            state_in = SWAP_WR_B;
         end
         SWAP_WR_B: begin
            wr_en   = 1'b1;
            wr_addr = b_ff;
            wr_data = hold_ff;
            if (left_ff == (COUNT_W-1)'(1)) begin
               rsp_valid_in     = 1'b1;
               rsp_in.data      = '0;
               rsp_in.status    = STATUS_OK;
               rsp_in.occupancy = COUNT_W'(count_ff);
               state_in         = IDLE;
            end else begin
               left_in  = left_ff - (COUNT_W-1)'(1);
               a_in     = (a_ff == AW'(DEPTH - 1)) ? '0 : a_ff + AW'(1);
               b_in     = (b_ff == '0) ? AW'(DEPTH - 1) : b_ff - AW'(1);
               state_in = SWAP_RD_A;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         head_ff      <= '0;
         tail_ff      <= AW'(DEPTH - 1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      left_ff <= left_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W - WORD_W - COUNT_W){1'b0}}, rsp_ff.occupancy, rsp_ff.data};
   assign rsp_tuser  = rsp_ff.status;

endmodule

### verif/tb_circular_queue_reverse_first_k.sv
// Self-checking bench for the circular queue with first-k reversal. A directed
// opening walks the queue through empty, full and every status. Random traffic
// follows, with the queue level steered between those extremes. Every accepted
// request is run through a mirror of the queue held here as a SystemVerilog queue
// of words, and the reply that the mirror predicts waits in a queue until the
// matching response item arrives.
module tb_circular_queue_reverse_first_k;
   import cqrk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH  = 16;
   // Op code 3 is unused by the block: it must answer ok and change nothing.
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 625;
   // The last requests go in with neither side idling.
   localparam int CALM_ITEMS   = 80;
   // The sender waits for the queue of replies to drain before this random item.
   localparam int DRAIN_AT     = 400;
   // The receiver stops for a long stretch after this many responses.
   localparam int LONG_HOLD_AT = 120;
   localparam int LONG_HOLD    = 150;
   // The slowest item is a reversal of the whole queue.
   localparam int TAIL_CYCLES  = 40;
   localparam int IDLE_LIMIT   = 1000;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [WORD_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      bit                 drain_first;
   } queue_cmd_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;   // [31:0] value, [36:32] reverse_count, rest 0
   logic [OP_W-1:0]    req_tuser  = '0;   // [1:0] op
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [TDATA_W-1:0] rsp_tdata;         // [31:0] data_out, [36:32] occupancy, rest 0
   logic [STATUS_W-1:0] rsp_tuser;        // [1:0] status

   queue_cmd_type     pending_cmds[$];     // requests not yet offered
   queue_cmd_type     offered_cmd;         // request currently on the input
   logic [WORD_W-1:0] mirror_words[$];     // queue contents, oldest first
   rsp_type           awaited_replies[$];  // predicted responses, oldest first
   int                plan_level;          // queue level seen while building stimulus
   int                error_count = 0;
   bit                calm_tail = 1'b0;

   circular_queue_reverse_first_k #(.DEPTH(QUEUE_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Applies one operation to the mirror and returns the reply it must cause.
   // Errors leave the mirror untouched and return a zero word.
   function automatic rsp_type apply_queue_op(input queue_cmd_type cmd);
      rsp_type           reply;
      int                k;
      logic [WORD_W-1:0] swap_word;
      reply.data   = '0;
      reply.status = STATUS_OK;
      k = cmd.count;
      case (cmd.op)
         OP_ENQUEUE: begin
            if (mirror_words.size() >= QUEUE_DEPTH) reply.status = STATUS_FULL;
            else mirror_words.push_back(cmd.value);
         end
         OP_DEQUEUE: begin
            if (mirror_words.size() == 0) reply.status = STATUS_EMPTY;
            else reply.data = mirror_words.pop_front();
         end
         OP_REVERSE: begin
            // The first k words flip order; everything behind them stays put.
            if (k > mirror_words.size()) begin
               reply.status = STATUS_BADK;
            end else begin
               for (int i = 0; i < k / 2; i++) begin
                  swap_word               = mirror_words[i];
                  mirror_words[i]         = mirror_words[k - 1 - i];
                  mirror_words[k - 1 - i] = swap_word;
               end
            end
         end
         default: ;
      endcase
      reply.occupancy = COUNT_W'(mirror_words.size());
      return reply;
   endfunction

   // Queues one request and tracks the level it will leave, so that random
   // traffic can aim reversal counts at the current occupancy.
   task automatic plan_cmd(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value,
                           input int count, input bit drain_first);
      queue_cmd_type cmd;
      cmd.op          = op;
      cmd.value       = value;
      cmd.count       = COUNT_W'(count);
      cmd.drain_first = drain_first;
      pending_cmds.push_back(cmd);
      if (op == OP_ENQUEUE && plan_level < QUEUE_DEPTH) plan_level++;
      else if (op == OP_DEQUEUE && plan_level > 0) plan_level--;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      // Mostly random words, with the sign boundaries and patterns mixed in.
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Request driver. The item on the input is predicted at the edge where it is
   // taken; the next one is then chosen and every input gets one assignment.
   always @(posedge clock) begin : drive_requests
      logic          next_valid;
      queue_cmd_type next_cmd;
      static int     gap_left  = 0;
      static int     idle_pct  = 0;
      static int     cycle_cnt = 0;
      next_valid = req_tvalid;
      next_cmd   = offered_cmd;
      if (!reset) begin
         cycle_cnt++;
         // Idling comes and goes in phases, some of them without any gaps.
         if (cycle_cnt % 64 == 0) begin
            case ($urandom_range(3))
               0, 1: idle_pct = 0;
               2: idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         if (req_tvalid && req_tready) begin
            awaited_replies.push_back(apply_queue_op(offered_cmd));
            next_valid = 1'b0;
         end
         if (!next_valid && pending_cmds.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds[0].drain_first && awaited_replies.size() != 0) begin
               // Hold back until every reply in flight has come home.
            end else if (pending_cmds.size() > CALM_ITEMS &&
                         $urandom_range(99) < idle_pct) begin
               gap_left = $urandom_range(0, 6);
            end else begin
               next_cmd   = pending_cmds.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      offered_cmd = next_cmd;
      req_tvalid <= next_valid;
      req_tdata  <= TDATA_W'({next_cmd.count, next_cmd.value});
      req_tuser  <= next_cmd.op;
      calm_tail  <= (pending_cmds.size() <= CALM_ITEMS);
   end

   // Response monitor. It checks each response item against the oldest
   // prediction and decides the ready for the next cycle, including one long
   // hold that lets the block back up and stall its request side.
   always @(posedge clock) begin : check_responses
      rsp_type   got;
      rsp_type   want;
      logic      next_ready;
      static int hold_left = 0;
      static int gap_left  = 0;
      static int idle_pct  = 0;
      static int seen      = 0;
      static int cycle_cnt = 0;
      next_ready = 1'b0;
      if (!reset) begin
         cycle_cnt++;
         if (cycle_cnt % 48 == 0) begin
            case ($urandom_range(3))
               0: idle_pct = 0;
               1: idle_pct = 10;
               2: idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.data      = rsp_tdata[WORD_W-1:0];
            got.occupancy = rsp_tdata[WORD_W+COUNT_W-1:WORD_W];
            got.status    = status_type'(rsp_tuser);
            seen++;
            if (awaited_replies.size() == 0) begin
               $display("%0t: response with none expected, data %h status %0d occupancy %0d",
                        $time, got.data, got.status, got.occupancy);
               error_count++;
            end else begin
               want = awaited_replies.pop_front();
               if (got.data !== want.data) begin
                  $display("%0t: data_out expected %h actual %h", $time, want.data, got.data);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  error_count++;
               end
               if (got.occupancy !== want.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, want.occupancy, got.occupancy);
                  error_count++;
               end
            end
            if (seen == LONG_HOLD_AT) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (!calm_tail && $urandom_range(99) < idle_pct) begin
            gap_left = $urandom_range(0, 6);
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_tready <= next_ready;
   end

   // Watchdog: a run in which neither side moves for too long is hung.
   always @(posedge clock) begin : watch_progress
      static int stuck = 0;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck = 0;
         else stuck++;
         if (stuck >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin : run_test
      int enq_pct;
      int roll;
      plan_level = 0;

      // Directed opening: errors on the empty queue, the unused op code, a fill
      // to the brim with extreme words, overflow, a full-length reversal, a bad
      // count just past the level and a reversal of one.
      plan_cmd(OP_DEQUEUE, 32'h1234_5678, 0, 1'b0);
      plan_cmd(OP_REVERSE, 32'h0, 0, 1'b0);
      plan_cmd(OP_REVERSE, 32'h0, 1, 1'b0);
      plan_cmd(OP_SPARE, 32'hDEAD_BEEF, 16, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'h8000_0000, 16, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'h7FFF_FFFF, 0, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'hFFFF_FFFF, 31, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'h0000_0000, 5, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'h5555_5555, 10, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'hAAAA_AAAA, 21, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'h0000_0001, 3, 1'b0);
      while (plan_level < QUEUE_DEPTH) plan_cmd(OP_ENQUEUE, $urandom, 0, 1'b0);
      plan_cmd(OP_ENQUEUE, 32'h0BAD_F00D, 0, 1'b0);
      plan_cmd(OP_REVERSE, 32'h0, 16, 1'b0);
      plan_cmd(OP_DEQUEUE, 32'h0, 0, 1'b0);
      plan_cmd(OP_REVERSE, 32'h0, 16, 1'b0);
      plan_cmd(OP_REVERSE, 32'h0, 1, 1'b0);

      // Random traffic. The share of enqueues changes every few dozen items so
      // the level sweeps from empty to full; most reversal counts fit the level.
      enq_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) enq_pct = $urandom_range(10, 90);
         roll = $urandom_range(99);
         if (roll < 2) begin
            plan_cmd(OP_SPARE, $urandom, $urandom_range(0, 16), n == DRAIN_AT);
         end else if (roll < 24) begin
            plan_cmd(OP_REVERSE, $urandom,
                     ($urandom_range(9) == 0) ? $urandom_range(0, 16)
                                              : $urandom_range(0, plan_level),
                     n == DRAIN_AT);
         end else if ($urandom_range(99) < enq_pct) begin
            plan_cmd(OP_ENQUEUE, pick_word(), $urandom_range(0, 16), n == DRAIN_AT);
         end else begin
            plan_cmd(OP_DEQUEUE, $urandom, $urandom_range(0, 16), n == DRAIN_AT);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      // Any response beyond the last prediction shows up as an error here.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/cqrk_pkg.sv
rtl/cqrk_mem.sv
rtl/circular_queue_reverse_first_k.sv
verif/tb_circular_queue_reverse_first_k.sv
